>>> sv/bcfp_pkg.sv
package bcfp_pkg;

    // Framing bytes
    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] TERM1_BYTE = 8'h0A;
    localparam logic [7:0] TERM2_BYTE = 8'h0D;

    // Command codes with a payload or an explicit empty frame
    localparam logic [7:0] CMD_PAIR_A  = 8'd1;
    localparam logic [7:0] CMD_PAIR_B  = 8'd2;
    localparam logic [7:0] CMD_WIDE    = 8'd3;
    localparam logic [7:0] CMD_EMPTY_A = 8'd10;
    localparam logic [7:0] CMD_AXIS    = 8'd11;
    localparam logic [7:0] CMD_EMPTY_LO = 8'd12;
    localparam logic [7:0] CMD_EMPTY_HI = 8'd15;

    // Payload lengths in bytes
    localparam logic [3:0] PLEN_W16  = 4'd4;
    localparam logic [3:0] PLEN_W32  = 4'd8;
    localparam logic [3:0] PLEN_BYTE = 4'd1;
    localparam logic [3:0] PLEN_NONE = 4'd0;

    localparam int          PAYLOAD_BYTES = 8;
    localparam logic [15:0] TIMEOUT_RESET = 16'd150;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;
    localparam int          QUEUE_DEPTH_DEF = 4;

    // How the back end forms the two result words
    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_W16  = 2'd1,
        FMT_W32  = 2'd2,
        FMT_BYTE = 2'd3
    } fmt_t;

    typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_t;

    // One completed frame as queued between front and back
    typedef struct packed {
        logic [7:0] cmd;
        fmt_t       fmt;
        payload_t   payload;
    } frame_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

>>> sv/bcfp_front.sv
module bcfp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [7:0]           rx_byte,
    input  bcfp_pkg::queue_stat_t q_stat,
    output logic                 push,
    output bcfp_pkg::frame_t     push_frame
);
    import bcfp_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_HDR2  = 6'b000010,
        PH_CMD   = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_TERM1 = 6'b010000,
        PH_TERM2 = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    fmt_t        fmt_reg, fmt_next;
    logic [3:0]  payload_count_reg, payload_count_next;
    logic [3:0]  payload_expected_reg, payload_expected_next;
    payload_t    payload_reg, payload_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [15:0] timeout_reg;
    logic        in_fire;
    logic [3:0]  count_inc;

    // Accept whenever the queue can take a frame
    assign in_ready = !q_stat.full;
    assign in_fire  = in_valid && in_ready;
    assign count_inc = payload_count_reg + 4'd1;

    // Hold the timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Parse one transaction
    always_comb
    begin
        phase_next            = phase_reg;
        cmd_next              = cmd_reg;
        fmt_next              = fmt_reg;
        payload_count_next    = payload_count_reg;
        payload_expected_next = payload_expected_reg;
        payload_next          = payload_reg;
        tick_count_next       = tick_count_reg;
        push                  = 1'b0;
        if (in_fire)
        begin
            if (mode)
            begin
                // Count idle ticks, drop an open packet on timeout
                if (tick_count_reg != TICK_MAX)
                begin
                    tick_count_next = tick_count_reg + 16'd1;
                end
                if (phase_reg != PH_IDLE && tick_count_next > timeout_reg)
                begin
                    phase_next = PH_IDLE;
                end
            end
            else
            begin
                tick_count_next = '0;
                case (phase_reg)
                    PH_HDR2:
                    begin
                        phase_next = (rx_byte == HDR_BYTE) ? PH_CMD : PH_IDLE;
                    end
                    PH_CMD:
                    begin
                        cmd_next           = rx_byte;
                        payload_count_next = '0;
                        if (rx_byte == CMD_PAIR_A || rx_byte == CMD_PAIR_B)
                        begin
                            payload_expected_next = PLEN_W16;
                            fmt_next              = FMT_W16;
                            phase_next            = PH_DATA;
                        end
                        else if (rx_byte == CMD_WIDE)
                        begin
                            payload_expected_next = PLEN_W32;
                            fmt_next              = FMT_W32;
                            phase_next            = PH_DATA;
                        end
                        else if (rx_byte == CMD_AXIS)
                        begin
                            payload_expected_next = PLEN_BYTE;
                            fmt_next              = FMT_BYTE;
                            phase_next            = PH_DATA;
                        end
                        else if (rx_byte == CMD_EMPTY_A ||
                                 (rx_byte >= CMD_EMPTY_LO && rx_byte <= CMD_EMPTY_HI))
                        begin
                            payload_expected_next = PLEN_NONE;
                            fmt_next              = FMT_NONE;
                            phase_next            = PH_TERM1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_DATA:
                    begin
                        payload_next[payload_count_reg[2:0]] = rx_byte;
                        payload_count_next = count_inc;
                        if (count_inc >= payload_expected_reg)
                        begin
                            phase_next = PH_TERM1;
                        end
                    end
                    PH_TERM1:
                    begin
                        if (rx_byte == TERM1_BYTE)
                        begin
                            phase_next = PH_TERM2;
                        end
                        else
                        begin
                            phase_next = (rx_byte == HDR_BYTE) ? PH_HDR2 : PH_IDLE;
                        end
                    end
                    PH_TERM2:
                    begin
                        phase_next = PH_IDLE;
                        push       = (rx_byte == TERM2_BYTE);
                    end
                    default:
                    begin
                        phase_next = (rx_byte == HDR_BYTE) ? PH_HDR2 : PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign push_frame.cmd     = cmd_reg;
    assign push_frame.fmt     = fmt_reg;
    assign push_frame.payload = payload_reg;

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            cmd_reg              <= '0;
            fmt_reg              <= FMT_NONE;
            payload_count_reg    <= '0;
            payload_expected_reg <= '0;
            tick_count_reg       <= '0;
        end
        else
        begin
            phase_reg            <= phase_next;
            cmd_reg              <= cmd_next;
            fmt_reg              <= fmt_next;
            payload_count_reg    <= payload_count_next;
            payload_expected_reg <= payload_expected_next;
            tick_count_reg       <= tick_count_next;
        end
    end

    // Hold payload bytes
    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
    end

    a_timeout_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode && phase_reg != PH_IDLE && tick_count_next > timeout_reg)
        |=> phase_reg == PH_IDLE)
        else $error("open packet not dropped on timeout");

    a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> payload_count_reg < payload_expected_reg)
        else $error("payload count beyond expected length");

endmodule

>>> sv/bcfp_queue.sv
module bcfp_queue #(
    parameter int DEPTH = bcfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bcfp_pkg::frame_t      push_frame,
    input  logic                  pop,
    output bcfp_pkg::frame_t      head_frame,
    output bcfp_pkg::queue_stat_t q_stat
);
    import bcfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == FULL_CNT);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_frame   = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming frame
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue occupancy beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue occupancy not raised on push");

endmodule

>>> sv/bcfp_back.sv
module bcfp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bcfp_pkg::frame_t      head_frame,
    input  bcfp_pkg::queue_stat_t q_stat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            command_code,
    output logic [31:0]           value_first,
    output logic [31:0]           value_second
);
    import bcfp_pkg::*;

    logic        valid_reg, valid_next;
    logic [7:0]  cmd_reg;
    logic [31:0] first_reg, first_next;
    logic [31:0] second_reg, second_next;
    payload_t    p;

    assign p   = head_frame.payload;
    // Load the output register when it is free or being taken
    assign pop = !q_stat.empty && (!valid_reg || out_ready);

    // Form the big-endian words
    always_comb
    begin
        first_next  = '0;
        second_next = '0;
        case (head_frame.fmt)
            FMT_W16:
            begin
                first_next  = {16'd0, p[0], p[1]};
                second_next = {16'd0, p[2], p[3]};
            end
            FMT_W32:
            begin
                first_next  = {p[0], p[1], p[2], p[3]};
                second_next = {p[4], p[5], p[6], p[7]};
            end
            FMT_BYTE:
            begin
                first_next = {24'd0, p[0]};
            end
            default:
            begin
                first_next  = '0;
                second_next = '0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg    <= head_frame.cmd;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign out_valid    = valid_reg;
    assign command_code = cmd_reg;
    assign value_first  = first_reg;
    assign value_second = second_reg;

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg)
        else $error("frame taken from queue but no result shown");

endmodule

>>> sv/binary_command_frame_parser.sv
// Binary command frame parser: takes one transaction per clock while in_ready is high
// (a received byte or a time tick) and deframes packets FF FF cmd payload 0A 0D,
// emitting the command and two big-endian words per complete frame. The front end parses
// each transaction; completed frames pass through a QUEUE_DEPTH-entry queue to an output
// register, so in_ready stays high unless that queue is full; the queue head moves into
// that register when it is free or being read. The user must write timeout_ticks
// (reset 150) via cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
module binary_command_frame_parser #(
    parameter int QUEUE_DEPTH = bcfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  command_code,
    output logic [31:0] value_first,
    output logic [31:0] value_second
);
    import bcfp_pkg::*;

    queue_stat_t q_stat;
    frame_t      push_frame;
    frame_t      head_frame;
    logic        push;
    logic        pop;

    // Parse incoming transactions
    bcfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .rx_byte    (rx_byte),
        .q_stat     (q_stat),
        .push       (push),
        .push_frame (push_frame)
    );

    // Buffer completed frames
    bcfp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_frame(push_frame),
        .pop       (pop),
        .head_frame(head_frame),
        .q_stat    (q_stat)
    );

    // Format and present results
    bcfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_frame  (head_frame),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .command_code(command_code),
        .value_first (value_first),
        .value_second(value_second)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bcfp_pkg::*;

    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_TICK    = 1'b1;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   HOLD_CYCLES  = 300;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_HDR2  = 3'd1,
        ST_CMD   = 3'd2,
        ST_DATA  = 3'd3,
        ST_TERM1 = 3'd4,
        ST_TERM2 = 3'd5
    } parse_phase_t;

    typedef struct {
        logic [7:0]  cmd;
        logic [31:0] first;
        logic [31:0] second;
    } frame_result_t;

    typedef logic [7:0] octet_q_t[$];

    // Predict completed frames and compare them with what the block emits
    class frame_scoreboard;
        frame_result_t expected_frames[$];
        int unsigned   errors;
        logic [15:0]   timeout_ticks;
        parse_phase_t  phase;
        logic [7:0]    held_cmd;
        logic [3:0]    pay_count;
        logic [3:0]    pay_len;
        logic [7:0]    pay[8];
        logic [15:0]   idle_ticks;

        function new();
            errors        = 0;
            timeout_ticks = TIMEOUT_RESET;
            phase         = ST_IDLE;
            held_cmd      = '0;
            pay_count     = '0;
            pay_len       = '0;
            idle_ticks    = '0;
            foreach (pay[i]) pay[i] = '0;
        endfunction

        // Payload length of a command; returns 0 for an unknown command
        static function bit cmd_len(input logic [7:0] c, output logic [3:0] len);
            len = PLEN_NONE;
            if (c == CMD_PAIR_A || c == CMD_PAIR_B)
                len = PLEN_W16;
            else if (c == CMD_WIDE)
                len = PLEN_W32;
            else if (c == CMD_AXIS)
                len = PLEN_BYTE;
            else if (c == CMD_EMPTY_A || (c >= CMD_EMPTY_LO && c <= CMD_EMPTY_HI))
                len = PLEN_NONE;
            else
                return 1'b0;
            return 1'b1;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // Advance the parser by one accepted transaction
        function void note_transaction(input logic m, input logic [7:0] b);
            frame_result_t res;
            logic [3:0]    len;
            if (m == MODE_TICK) begin
                if (idle_ticks != TICK_MAX)
                    idle_ticks++;
                if (phase != ST_IDLE && idle_ticks > timeout_ticks)
                    phase = ST_IDLE;
                return;
            end
            idle_ticks = '0;
            case (phase)
                ST_HDR2:
                    phase = (b == HDR_BYTE) ? ST_CMD : ST_IDLE;
                ST_CMD:
                begin
                    held_cmd  = b;
                    pay_count = '0;
                    if (!cmd_len(b, len))
                        phase = ST_IDLE;
                    else
                    begin
                        pay_len = len;
                        phase   = (len == PLEN_NONE) ? ST_TERM1 : ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    pay[pay_count[2:0]] = b;
                    pay_count++;
                    if (pay_count >= pay_len)
                        phase = ST_TERM1;
                end
                ST_TERM1:
                begin
                    if (b == TERM1_BYTE)
                        phase = ST_TERM2;
                    else
                        phase = (b == HDR_BYTE) ? ST_HDR2 : ST_IDLE;
                end
                ST_TERM2:
                begin
                    phase = ST_IDLE;
                    if (b == TERM2_BYTE)
                    begin
                        res.cmd    = held_cmd;
                        res.first  = '0;
                        res.second = '0;
                        case (held_cmd)
                            CMD_PAIR_A, CMD_PAIR_B:
                            begin
                                res.first  = {16'h0, pay[0], pay[1]};
                                res.second = {16'h0, pay[2], pay[3]};
                            end
                            CMD_WIDE:
                            begin
                                res.first  = {pay[0], pay[1], pay[2], pay[3]};
                                res.second = {pay[4], pay[5], pay[6], pay[7]};
                            end
                            CMD_AXIS:
                                res.first = {24'h0, pay[0]};
                            default:
                                res.first = '0;
                        endcase
                        expected_frames.push_back(res);
                    end
                end
                default:
                    phase = (b == HDR_BYTE) ? ST_HDR2 : ST_IDLE;
            endcase
        endfunction

        // Compare an emitted frame with the oldest prediction
        function void check_frame(input logic [7:0] c, input logic [31:0] f,
                                  input logic [31:0] s);
            frame_result_t want;
            if (expected_frames.size() == 0)
            begin
                $error("unexpected frame: command_code %0d value_first %0h value_second %0h",
                       c, f, s);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            if (c !== want.cmd)
            begin
                $error("command_code: expected %0d, actual %0d", want.cmd, c);
                errors++;
            end
            if (f !== want.first)
            begin
                $error("value_first: expected %0h, actual %0h", want.first, f);
                errors++;
            end
            if (s !== want.second)
            begin
                $error("value_second: expected %0h, actual %0h", want.second, s);
                errors++;
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [15:0] cfg_wr_data  = '0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic        mode         = MODE_BYTE;
    logic [7:0]  rx_byte      = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [7:0]  command_code;
    logic [31:0] value_first;
    logic [31:0] value_second;

    frame_scoreboard sb;
    logic [7:0]      known_cmds[9];
    logic [15:0]     timeout_now      = TIMEOUT_RESET;
    bit              idling_on        = 1'b1;
    bit              hold_off_request = 1'b0;
    int              tick_pct         = 0;
    int              items_sent       = 0;

    binary_command_frame_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command_code (command_code),
        .value_first  (value_first),
        .value_second (value_second)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one transaction, with an occasional gap first, and hold it until accepted
    task automatic send_item(input logic m, input logic [7:0] b);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_transaction(m, b);
        items_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Send bytes, slipping in runs of ticks now and then
    task automatic send_octets(input octet_q_t q);
        int k;
        foreach (q[i])
        begin
            if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct)
            begin
                if ($urandom_range(0, 7) == 0 && timeout_now < 16'd1000)
                    k = int'(timeout_now) + $urandom_range(0, 2);
                else
                    k = $urandom_range(1, 3);
                send_ticks(k);
            end
            send_item(MODE_BYTE, q[i]);
        end
    endtask

    function automatic octet_q_t frame_of(input logic [7:0] c, input octet_q_t body);
        octet_q_t q;
        q.push_back(HDR_BYTE);
        q.push_back(HDR_BYTE);
        q.push_back(c);
        foreach (body[i]) q.push_back(body[i]);
        q.push_back(TERM1_BYTE);
        q.push_back(TERM2_BYTE);
        return q;
    endfunction

    // Random byte, leaning towards the framing values and the extremes
    function automatic logic [7:0] pick_octet();
        case ($urandom_range(0, 7))
            0: return HDR_BYTE;
            1: return TERM1_BYTE;
            2: return TERM2_BYTE;
            3: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Drop valid and wait until every predicted frame has arrived
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.timeout_ticks = v;
        timeout_now      = v;
    endtask

    // Mostly well-formed frames with random content, plus broken frames and noise
    task automatic random_traffic(input int n_items);
        int         stop_at;
        int         kind;
        int         pos;
        octet_q_t   q;
        octet_q_t   body;
        logic [7:0] c;
        logic [3:0] len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            q.delete();
            body.delete();
            if (kind < 85)
            begin
                c = known_cmds[$urandom_range(0, 8)];
                void'(frame_scoreboard::cmd_len(c, len));
                repeat (len) body.push_back(pick_octet());
                q = frame_of(c, body);
                // corrupt one byte or cut the frame short
                if (kind >= 70)
                begin
                    pos = $urandom_range(1, q.size() - 1);
                    if ($urandom_range(0, 1) == 1)
                        q[pos] = pick_octet();
                    else
                        while (q.size() > pos) void'(q.pop_back());
                end
            end
            else if (kind < 93)
                repeat ($urandom_range(1, 6)) q.push_back(pick_octet());
            else
            begin
                q.push_back(HDR_BYTE);
                q.push_back(HDR_BYTE);
                q.push_back(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 4)) q.push_back(pick_octet());
            end
            send_octets(q);
        end
    endtask

    // Result side: check accepted frames, then choose the next ready value
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_frame(command_code, value_first, value_second);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left        = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        octet_q_t none;
        sb = new();
        known_cmds = '{CMD_PAIR_A, CMD_PAIR_B, CMD_WIDE, CMD_EMPTY_A, CMD_AXIS,
                       CMD_EMPTY_LO, CMD_EMPTY_LO + 8'd1, CMD_EMPTY_LO + 8'd2, CMD_EMPTY_HI};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ticks and noise in idle, every command, every framing fault
        send_item(MODE_TICK, 8'h00);
        send_item(MODE_TICK, 8'hFF);
        send_octets('{8'h00, TERM1_BYTE, TERM2_BYTE});
        send_octets(frame_of(CMD_PAIR_A, '{8'hFF, 8'hFF, 8'hFF, 8'hFF}));
        send_octets(frame_of(CMD_PAIR_B, '{8'h00, 8'h00, 8'h00, 8'h00}));
        send_octets(frame_of(CMD_WIDE, '{8'h01, 8'h23, 8'h45, 8'h67,
                                         8'h89, 8'hAB, 8'hCD, 8'hEF}));
        send_octets(frame_of(CMD_AXIS, '{8'hFF}));
        send_octets(frame_of(CMD_EMPTY_A, none));
        for (int c = CMD_EMPTY_LO; c <= CMD_EMPTY_HI; c++)
            send_octets(frame_of(8'(c), none));
        // unknown commands
        send_octets('{HDR_BYTE, HDR_BYTE, 8'h00});
        send_octets('{HDR_BYTE, HDR_BYTE, 8'h04, TERM1_BYTE, TERM2_BYTE});
        send_octets('{HDR_BYTE, HDR_BYTE, HDR_BYTE});
        // bad second header
        send_octets('{HDR_BYTE, TERM1_BYTE});
        // header byte in the first terminator slot restarts the frame
        send_octets('{HDR_BYTE, HDR_BYTE, CMD_EMPTY_A, HDR_BYTE, HDR_BYTE,
                      CMD_EMPTY_LO, TERM1_BYTE, TERM2_BYTE});
        // wrong first and second terminators
        send_octets('{HDR_BYTE, HDR_BYTE, CMD_EMPTY_A, 8'h00});
        send_octets('{HDR_BYTE, HDR_BYTE, CMD_EMPTY_A, TERM1_BYTE, TERM1_BYTE});
        // timeout at the reset value: exactly at the limit survives, one more drops
        send_octets('{HDR_BYTE, HDR_BYTE, CMD_PAIR_A, 8'hAA});
        send_ticks(TIMEOUT_RESET);
        send_octets('{8'hBB, 8'hCC, 8'hDD, TERM1_BYTE, TERM2_BYTE});
        send_octets('{HDR_BYTE, HDR_BYTE, CMD_PAIR_A});
        send_ticks(TIMEOUT_RESET + 1);
        send_octets('{8'h11, 8'h22, 8'h33, 8'h44, TERM1_BYTE, TERM2_BYTE});

        // Zero timeout: the first tick closes an open packet
        write_timeout(16'd0);
        send_octets('{HDR_BYTE, HDR_BYTE, CMD_EMPTY_A});
        send_ticks(1);
        send_octets('{TERM1_BYTE, TERM2_BYTE});
        tick_pct = 6;
        random_traffic(70);

        // Timeout of one tick
        write_timeout(16'd1);
        tick_pct = 0;
        send_octets('{HDR_BYTE, HDR_BYTE, CMD_EMPTY_A});
        send_ticks(1);
        send_octets('{TERM1_BYTE, TERM2_BYTE, HDR_BYTE, HDR_BYTE, CMD_EMPTY_A});
        send_ticks(2);
        send_octets('{TERM1_BYTE, TERM2_BYTE});
        tick_pct = 6;
        random_traffic(70);

        // Largest timeout: a run of ticks past the reset limit leaves the packet open
        write_timeout(16'hFFFF);
        tick_pct  = 0;
        idling_on = 1'b0;
        send_octets('{HDR_BYTE, HDR_BYTE, CMD_AXIS, 8'h5A});
        send_ticks(160);
        send_octets('{TERM1_BYTE, TERM2_BYTE});
        idling_on = 1'b1;
        tick_pct  = 6;
        random_traffic(50);

        write_timeout(16'd3);
        random_traffic(120);

        // Back to the reset value; hold the result side off so the input stalls
        write_timeout(TIMEOUT_RESET);
        tick_pct         = 0;
        hold_off_request = 1'b1;
        repeat (30) send_octets(frame_of(CMD_EMPTY_LO, none));
        tick_pct = 3;
        random_traffic(130);

        write_timeout(16'($urandom_range(1, 20)));
        tick_pct = 6;
        random_traffic(80);
        idling_on = 1'b0;
        random_traffic(80);

        settle();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
